[hw/rtl/mbps_pkg.sv]
// Shared types and constants for the masked byte pattern search block.
`timescale 1ns / 1ps

package mbps_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int OFFSET_W    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH  = 3'd0,
    CFG_PATTERN_BYTES_A = 3'd1,
    CFG_PATTERN_BYTES_B = 3'd2,
    CFG_PATTERN_BYTES_C = 3'd3,
    CFG_PATTERN_BYTES_D = 3'd4,
    CFG_CARE_MASK       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_last;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
  } out_item_t;

  // Per-cell compare reference
  typedef struct packed {
    logic [7:0] want;
    logic       care;
  } cell_ref_t;

endpackage

[hw/rtl/mbps_cell.sv]
// One window cell: holds one byte, passes it on, and compares its incoming byte.
`timescale 1ns / 1ps

module mbps_cell (
  input  logic               clk,
  input  logic               shift_en,
  input  logic [7:0]         byte_in,
  input  mbps_pkg::cell_ref_t ref_in,
  output logic [7:0]         byte_out,
  output logic               hit
);
  import mbps_pkg::*;

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  // the incoming byte is what this slot holds once the item is taken
  assign hit      = !ref_in.care || (byte_in == ref_in.want);
  assign byte_out = byte_r;

endmodule

[hw/rtl/mbps_out_buf.sv]
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps

module mbps_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mbps_pkg::out_item_t push_data,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output mbps_pkg::out_item_t out_data
);
  import mbps_pkg::*;

  logic      head_v_r, head_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t head_r, head_nxt;
  out_item_t skid_r, skid_nxt;
  logic      pop;

  assign pop      = head_v_r && out_ready;
  assign can_push = !skid_v_r;

  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        head_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (!head_v_r || pop) begin
      head_v_nxt = push;
      head_nxt   = push_data;
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = head_v_r;
  assign out_data  = head_r;

endmodule

[hw/rtl/masked_byte_pattern_search.sv]
// Top level of the masked byte pattern search: config registers, cell chain, result path.
`timescale 1ns / 1ps

// Scans a byte stream, one item per byte, for the first place where a masked
// pattern of up to 32 bytes matches. Items may follow back to back while the
// output buffer has room: the window is a chain of 32 byte cells that shift
// every accepted item, and all cells compare in parallel against the pattern
// byte lined up with them, so the match decision is made in the accept cycle.
// A result (found with start offset, or not-found on the region's last byte)
// is registered into the two-entry output buffer; input stalls only while
// both entries are held by a stalled consumer. Configuration writes are always
// accepted (cfg_ready tied high) and must only be issued while the block is idle.
module masked_byte_pattern_search (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mbps_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mbps_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mbps_pkg::*;

  // configuration registers
  logic [LEN_W-1:0]       len_r;
  logic [3:0][63:0]       pat_words_r;
  logic [MAX_PATTERN-1:0] care_r;

  // scan state
  logic [OFFSET_W-1:0] seen_r, seen_nxt;
  logic                reported_r, reported_nxt;

  logic                             accept;
  logic [MAX_PATTERN-1:0][7:0]      pat_bytes;
  logic [MAX_PATTERN:0][7:0]        win;
  logic [MAX_PATTERN-1:0]           hit;
  cell_ref_t [MAX_PATTERN-1:0]      cell_ref;
  logic                             len_ok;
  logic                             match;
  logic                             push;
  out_item_t                        push_data;
  logic                             buf_can_push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pat_words_r <= '0;
      care_r      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PATTERN_LENGTH:  len_r          <= cfg_data[LEN_W-1:0];
        CFG_PATTERN_BYTES_A: pat_words_r[0] <= cfg_data;
        CFG_PATTERN_BYTES_B: pat_words_r[1] <= cfg_data;
        CFG_PATTERN_BYTES_C: pat_words_r[2] <= cfg_data;
        CFG_PATTERN_BYTES_D: pat_words_r[3] <= cfg_data;
        CFG_CARE_MASK:       care_r         <= cfg_data[MAX_PATTERN-1:0];
        default: ; // unmapped index: write ignored
      endcase
    end
  end

  assign pat_bytes = pat_words_r;

  assign in_ready = buf_can_push;
  assign accept   = in_valid && in_ready;

  // Window slot k (0 = newest) lines up with pattern byte len-1-k.
  // Slots at or beyond the pattern length don't care.
  assign win[0] = in_data.data_byte;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    localparam logic [LEN_W-1:0] SLOT = LEN_W'(k);
    logic [LEN_W-1:0] pj;

    assign pj              = len_r - SLOT - LEN_W'(1);
    assign cell_ref[k].want = pat_bytes[pj[PAT_IDX_W-1:0]];
    assign cell_ref[k].care = (SLOT < len_r) && care_r[pj[PAT_IDX_W-1:0]];

    mbps_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .byte_in  (win[k]),
      .ref_in   (cell_ref[k]),
      .byte_out (win[k+1]),
      .hit      (hit[k])
    );
  end

  // saturating byte count, including the byte taken now
  assign seen_nxt = (seen_r == '1) ? seen_r : seen_r + OFFSET_W'(1);

  assign len_ok = (len_r != '0) && (len_r <= LEN_W'(MAX_PATTERN));
  assign match  = !reported_r && len_ok && (seen_nxt >= OFFSET_W'(len_r)) && (&hit);

  always_comb begin
    push                   = 1'b0;
    push_data.found        = 1'b0;
    push_data.match_offset = '0;
    reported_nxt           = reported_r;
    if (accept) begin
      if (match) begin
        push                   = 1'b1;
        push_data.found        = 1'b1;
        push_data.match_offset = seen_nxt - OFFSET_W'(len_r);
        reported_nxt           = 1'b1;
      end else if (in_data.region_last && !reported_r) begin
        push = 1'b1; // not-found at region end
      end
      if (in_data.region_last) begin
        reported_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      reported_r <= 1'b0;
    end else begin
      reported_r <= reported_nxt;
      if (accept) begin
        seen_r <= in_data.region_last ? '0 : seen_nxt;
      end
    end
  end

  mbps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .can_push  (buf_can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/mbps_checker.sv]
// Port-level assertions for the masked byte pattern search, bound to the top level.
`timescale 1ns / 1ps

module mbps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mbps_pkg::out_item_t out_data
);
  import mbps_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.match_offset == '0)
    else $error("not-found item with nonzero offset");

  // input only backs up behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[verif/mbps_scan_checker.sv]
// Result checker for the masked byte pattern search: tracks the scan, predicts and compares.
`timescale 1ns / 1ps

module mbps_scan_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  mbps_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  mbps_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              expected_left
);
  import mbps_pkg::*;

  // Register copies
  logic [LEN_W-1:0]         pat_len;
  logic [8*MAX_PATTERN-1:0] pat_bytes;
  logic [MAX_PATTERN-1:0]   pat_care;

  // Scan state: entry 0 of the window is the newest byte
  logic [7:0]  scan_window [MAX_PATTERN];
  logic [31:0] bytes_taken;
  logic        hit_reported;
  int          regions_done;

  out_item_t expected_hits [$];

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic clear_scan();
    for (int k = 0; k < MAX_PATTERN; k++) scan_window[k] = 8'h00;
    bytes_taken  = '0;
    hit_reported = 1'b0;
  endtask

  always @(posedge clk) begin : scan_model
    logic      hit;
    int        j, k, n;
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      clear_scan();
      pat_len   = '0;
      pat_bytes = '0;
      pat_care  = '0;
      expected_hits.delete();
      regions_done = 0;
    end else begin
      // item taken: shift the window and test it with the registers as they stand
      if (in_valid && in_ready) begin
        n = int'(pat_len);
        for (k = MAX_PATTERN - 1; k > 0; k--) scan_window[k] = scan_window[k-1];
        scan_window[0] = in_data.data_byte;
        if (bytes_taken != '1) bytes_taken++;
        hit = !hit_reported && n != 0 && n <= MAX_PATTERN && bytes_taken >= 32'(n);
        for (j = 0; j < MAX_PATTERN; j++)
          if (hit && j < n && pat_care[j] && scan_window[n-1-j] != pat_bytes[8*j +: 8])
            hit = 1'b0;
        if (hit) begin
          hit_reported      = 1'b1;
          want.found        = 1'b1;
          want.match_offset = bytes_taken - 32'(n);
          expected_hits     = {expected_hits, want};
        end
        if (in_data.region_last) begin
          if (!hit_reported) begin
            want          = '0;
            expected_hits = {expected_hits, want};
          end
          clear_scan();
          regions_done++;
        end
      end

      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_hits.size() == 0) begin
          flag_mismatch($sformatf("result with none pending: found=%0b offset=%0d",
                                  got.found, got.match_offset));
        end else begin
          want = expected_hits.pop_front();
          if (got.found !== want.found)
            flag_mismatch($sformatf("found %0b, predicted %0b (regions closed %0d)",
                                    got.found, want.found, regions_done));
          if (got.match_offset !== want.match_offset)
            flag_mismatch($sformatf("offset %0d, predicted %0d (regions closed %0d)",
                                    got.match_offset, want.match_offset, regions_done));
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_PATTERN_LENGTH:  pat_len           = cfg_data[LEN_W-1:0];
          CFG_PATTERN_BYTES_A: pat_bytes[63:0]   = cfg_data;
          CFG_PATTERN_BYTES_B: pat_bytes[127:64] = cfg_data;
          CFG_PATTERN_BYTES_C: pat_bytes[191:128] = cfg_data;
          CFG_PATTERN_BYTES_D: pat_bytes[255:192] = cfg_data;
          CFG_CARE_MASK:       pat_care          = cfg_data[MAX_PATTERN-1:0];
          default: ;
        endcase
      end
    end
    expected_left = expected_hits.size();
  end

endmodule

[verif/masked_byte_pattern_search_test.sv]
// Testbench top for the masked byte pattern search: stimulus, idling phases and verdict.
`timescale 1ns / 1ps

module masked_byte_pattern_search_test;
  import mbps_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int expected_left;

  // Idling odds in percent, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Pattern as last programmed; used to build regions that hit it
  logic [LEN_W-1:0]         cur_len  = '0;
  logic [8*MAX_PATTERN-1:0] cur_pat  = '0;
  logic [MAX_PATTERN-1:0]   cur_care = '0;

  always #5 clk = ~clk;

  masked_byte_pattern_search uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mbps_scan_checker scan_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // Receiver: one fresh draw per cycle, so stalls land anywhere in a region.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Hard stop; far beyond the slowest legal run at the heaviest idling.
  initial begin
    #5_000_000;
    $display("masked_byte_pattern_search verification failed");
    $finish;
  end

  // One byte item. Optional idle cycles go in front; valid then holds until taken.
  // Returns at the edge that took the item.
  task automatic push_byte(input logic [7:0] b, input logic last);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= {b, last};  // data_byte, region_last
    do @(posedge clk); while (!in_ready);
  endtask

  // Register write; cfg_valid stays up so writes can go back to back.
  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Every register, every time, so the local copy can't drift from the block.
  task automatic program_pattern(input logic [LEN_W-1:0] len,
                                 input logic [8*MAX_PATTERN-1:0] pat,
                                 input logic [MAX_PATTERN-1:0] care);
    write_reg(CFG_PATTERN_LENGTH,  64'(len));
    write_reg(CFG_PATTERN_BYTES_A, pat[63:0]);
    write_reg(CFG_PATTERN_BYTES_B, pat[127:64]);
    write_reg(CFG_PATTERN_BYTES_C, pat[191:128]);
    write_reg(CFG_PATTERN_BYTES_D, pat[255:192]);
    write_reg(CFG_CARE_MASK,       64'(care));
    cfg_valid <= 1'b0;
    cur_len  = len;
    cur_pat  = pat;
    cur_care = care;
  endtask

  // Block goes idle: every predicted result delivered, then a few cycles for an
  // item that produced nothing to finish inside the block. The count is read
  // on the falling edge, clear of the checker's update.
  task automatic drain_and_settle(input int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_left != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Half fully random, half lifted from the pattern so near hits are common.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(1)) return 8'($urandom_range(255));
    return cur_pat[8*$urandom_range(MAX_PATTERN - 1) +: 8];
  endfunction

  // New register set. The selector walks the extremes in turn: full-length
  // pattern with every byte cared, empty pattern, pattern too long, single
  // byte, then ordinary lengths with wildcards.
  task automatic pick_setting(input int sel);
    logic [8*MAX_PATTERN-1:0] p;
    logic [LEN_W-1:0]         l;
    logic [MAX_PATTERN-1:0]   m;
    for (int k = 0; k < MAX_PATTERN / 4; k++) p[32*k +: 32] = $urandom();
    m = $urandom();
    case (sel % 6)
      0: begin
        l = LEN_W'(MAX_PATTERN);
        m = '1;
        if ($urandom_range(1)) p = '1;
      end
      1: l = '0;
      2: begin
        l = ($urandom_range(2) == 0) ? '1 : LEN_W'($urandom_range(MAX_PATTERN + 1, 63));
      end
      3: begin
        l = LEN_W'(1);
        if ($urandom_range(1)) p = '0;
      end
      default: begin
        l = LEN_W'($urandom_range(2, MAX_PATTERN - 1));
        if ($urandom_range(4) == 0) m = '0;
        else m = m | $urandom();
      end
    endcase
    program_pattern(l, p, m);
  endtask

  // One region. With a usable pattern most regions carry a copy of it at a
  // random offset (wildcard spots random), some of those with one cared byte
  // spoiled; the rest are plain noise, short ones included. Embedded regions
  // end shortly after the copy, so few bytes fall after the hit. Every byte
  // sent is counted.
  task automatic scan_random_region(inout int counted);
    logic [7:0] region_bytes [64];
    int plen, lead, tail, rlen, kind, j, tries;
    plen = (cur_len <= MAX_PATTERN) ? int'(cur_len) : 0;
    kind = $urandom_range(99);
    if (plen != 0 && kind < 70) begin
      lead = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      tail = $urandom_range(0, 3);
      rlen = lead + plen + tail;
      for (j = 0; j < rlen; j++) region_bytes[j] = pick_byte();
      for (j = 0; j < plen; j++)
        if (cur_care[j] || $urandom_range(1)) region_bytes[lead + j] = cur_pat[8*j +: 8];
      if (kind >= 50) begin
        for (tries = 0; tries < 8; tries++) begin
          j = $urandom_range(plen - 1);
          if (cur_care[j]) begin
            region_bytes[lead + j] ^= 8'($urandom_range(1, 255));
            break;
          end
        end
      end
    end else begin
      rlen = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40);
      for (j = 0; j < rlen; j++) region_bytes[j] = pick_byte();
    end
    counted += rlen;
    for (j = 0; j < rlen; j++) push_byte(region_bytes[j], j == rlen - 1);
  endtask

  initial begin
    int phase_items, setting_no, mark;
    logic [8*MAX_PATTERN-1:0] p;
    setting_no = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // registers still at reset: empty pattern, region closes not-found
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    drain_and_settle(4);

    // one-byte pattern: hit at offset 1, later bytes ignored, single result
    program_pattern(6'd1, 256'hFF, 32'h1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    // hit on the last byte: found only, no not-found behind it
    push_byte(8'hFF, 1'b1);
    drain_and_settle(4);

    // length past the window: never hits even on matching bytes
    program_pattern(6'd33, '1, '1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    drain_and_settle(4);
    program_pattern('1, '0, '1);
    push_byte(8'h00, 1'b1);
    drain_and_settle(4);

    // all wildcards, length 4: short region misses, next hits at offset 0
    for (int k = 0; k < MAX_PATTERN / 4; k++) p[32*k +: 32] = $urandom();
    program_pattern(6'd4, p, '0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h3C, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h11, 1'b1);

    // --- random, four idling phases ---
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_settle(4);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      phase_items = 0;
      while (phase_items < 313) begin
        drain_and_settle(4);
        pick_setting(setting_no);
        setting_no++;
        mark = phase_items;
        while (phase_items - mark < 45 && phase_items < 313)
          scan_random_region(phase_items);
      end
    end

    // all taken; let anything stray surface before the verdict
    drain_and_settle(16);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("masked_byte_pattern_search verification clean");
    end else begin
      $display("masked_byte_pattern_search verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cell.sv
hw/rtl/mbps_out_buf.sv
hw/rtl/masked_byte_pattern_search.sv
hw/rtl/mbps_checker.sv
verif/mbps_scan_checker.sv
verif/masked_byte_pattern_search_test.sv
